FILE: rtl/adp_pkg.sv
// Shared types and constants for the adaptive decorrelation pass.
package adp_pkg;

  localparam int HIST_DEPTH = 8;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 4;

  localparam logic [4:0] TERM_LINEAR   = 5'd17;
  localparam logic [4:0] TERM_WLINEAR  = 5'd18;
  localparam logic [31:0] ROUND_HALF   = 32'd512;
  localparam logic [31:0] LOW_HALF_MSK = 32'h0000_ffff;

  typedef enum logic [1:0] {
    REG_TERM_CODE    = 2'd0,
    REG_ADAPT_STEP   = 2'd1,
    REG_START_WEIGHT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]         term_code;
    logic [2:0]         adapt_step;
    logic signed [11:0] start_weight;
  } cfg_t;

  typedef struct packed {
    logic                  fire;
    logic                  load;
    logic                  linear;
    logic [HIST_IDX_W-1:0] slot;
    logic [HIST_IDX_W-1:0] term_idx;
    logic [DATA_W-1:0]     data;
  } hist_upd_t;

endpackage

FILE: rtl/adp_if.sv
// Request and result channel interfaces.
interface adp_in_if;
  import adp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] value;
  logic [HIST_IDX_W-1:0]    slot;
  modport source (output valid, cmd, value, slot, input ready);
  modport sink   (input valid, cmd, value, slot, output ready);
endinterface

interface adp_out_if;
  import adp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] decoded_sample;
  logic signed [DATA_W-1:0] weight_now;
  modport source (output valid, decoded_sample, weight_now, input ready);
  modport sink   (input valid, decoded_sample, weight_now, output ready);
endinterface

FILE: rtl/adaptive_decorrelation_pass_core.sv
// A decode request is registered in the input register, then in the result register.
// Throughput: one request per cycle unless a result stalls; weight and history close
// their loop combinationally through the prediction, the weighting multiplier
// and the residual add. Load requests give no result and never wait on the result slot.
// Reset: synchronous; clears history, weight, ring pointer, valid flags and loads
// the register defaults (term 1, step 0, start weight 0). No clearing pass.
module adaptive_decorrelation_pass_core
  import adp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  adp_in_if.sink             items,
  adp_out_if.source          results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t                  cfg;
  hist_upd_t             upd;
  logic                  q_valid, q_cmd, q_fire;
  logic [DATA_W-1:0]     q_value;
  logic [HIST_IDX_W-1:0] q_slot;
  logic [DATA_W-1:0]     weight, weight_next, hist_a, hist_b, pred, weighted, dec;
  logic [HIST_IDX_W-1:0] ptr;
  logic                  res_valid;
  logic [DATA_W-1:0]     res_sample, res_weight;

  adp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  adp_history u_hist (
    .clk, .rst, .upd, .hist_a, .hist_b, .ptr
  );

  adp_weigh u_weigh (
    .term_code (cfg.term_code),
    .hist_a, .hist_b, .weight, .pred, .weighted
  );

  // Advance the input register when it holds a load, or when the result slot is free or is drained.
  assign q_fire      = q_valid && (q_cmd || !res_valid || results.ready);
  assign items.ready = !q_valid || q_fire;

  assign dec = weighted + q_value;

  assign upd.fire     = q_fire;
  assign upd.load     = q_cmd;
  assign upd.linear   = (cfg.term_code == TERM_LINEAR) || (cfg.term_code == TERM_WLINEAR);
  assign upd.slot     = q_slot;
  assign upd.term_idx = cfg.term_code[HIST_IDX_W-1:0];
  assign upd.data     = q_cmd ? q_value : dec;

  always_comb begin
    weight_next = weight;
    if (q_cmd) begin
      weight_next = DATA_W'(cfg.start_weight);
    end else if (pred != '0 && q_value != '0) begin
      if (pred[31] ^ q_value[31]) begin
        weight_next = weight - DATA_W'(cfg.adapt_step);
      end else begin
        weight_next = weight + DATA_W'(cfg.adapt_step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      weight    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (items.ready) begin
        q_valid <= items.valid;
      end
      if (q_fire) begin
        weight <= weight_next;
      end
      if (q_fire && !q_cmd) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      q_cmd   <= items.cmd;
      q_value <= items.value;
      q_slot  <= items.slot;
    end
    if (q_fire && !q_cmd) begin
      res_sample <= dec;
      res_weight <= weight_next;
    end
  end

  assign results.valid          = res_valid;
  assign results.decoded_sample = res_sample;
  assign results.weight_now     = res_weight;

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (q_fire && q_cmd) |=> (res_valid == $past(res_valid && !results.ready)))
    else $error("load request changed the result slot");

  a_decode_result: assert property (@(posedge clk) disable iff (rst)
    (q_fire && !q_cmd) |=> (res_valid && results.weight_now == weight))
    else $error("decode result missing or weight mismatch");

  a_load_ptr: assert property (@(posedge clk) disable iff (rst)
    (q_fire && q_cmd) |=> (ptr == '0))
    else $error("ring pointer not cleared by load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !results.ready && q_valid && !q_cmd) |-> !q_fire)
    else $error("decode advanced over a stalled result");

endmodule

FILE: rtl/adp_regs.sv
// APB configuration registers.
module adp_regs
  import adp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.term_code    <= 5'd1;
      cfg.adapt_step   <= 3'd0;
      cfg.start_weight <= 12'sd0;
    end else if (wr) begin
      unique case (idx)
        REG_TERM_CODE:    cfg.term_code    <= pwdata[4:0];
        REG_ADAPT_STEP:   cfg.adapt_step   <= pwdata[2:0];
        REG_START_WEIGHT: cfg.start_weight <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TERM_CODE:    prdata = {27'd0, cfg.term_code};
      REG_ADAPT_STEP:   prdata = {29'd0, cfg.adapt_step};
      REG_START_WEIGHT: prdata = {20'd0, cfg.start_weight};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/adp_weigh.sv
// Prediction and weighting of the prediction by the adaptive weight.
module adp_weigh
  import adp_pkg::*;
(
  input  logic [4:0]        term_code,
  input  logic [DATA_W-1:0] hist_a,
  input  logic [DATA_W-1:0] hist_b,
  input  logic [DATA_W-1:0] weight,
  output logic [DATA_W-1:0] pred,
  output logic [DATA_W-1:0] weighted
);

  logic [DATA_W-1:0] lin2, lin3, mul_op, hi_op, prod0, prod1;
  logic [DATA_W-1:0] small_sum, split_lo, split_sum;
  logic              short_pred;

  assign lin2 = (hist_a << 1) - hist_b;
  assign lin3 = (hist_a << 1) + hist_a - hist_b;

  always_comb begin
    case (term_code)
      TERM_LINEAR:  pred = lin2;
      TERM_WLINEAR: pred = DATA_W'($signed(lin3) >>> 1);
      default:      pred = hist_a;
    endcase
  end

  // Short predictions take the 16-bit formula, others the split one.
  assign short_pred = (pred[31:15] == '0) || (pred[31:15] == '1);
  assign mul_op     = short_pred ? pred : (pred & LOW_HALF_MSK);
  assign hi_op      = {{16{pred[31]}}, pred[31:16]};
  assign prod0      = weight * mul_op;
  assign prod1      = (weight * hi_op) << 7;

  assign small_sum = prod0 + ROUND_HALF;
  assign split_lo  = DATA_W'($signed(prod0) >>> 9);
  assign split_sum = split_lo + prod1 + 32'd1;

  assign weighted = short_pred ? DATA_W'($signed(small_sum) >>> 10)
                               : DATA_W'($signed(split_sum) >>> 1);

endmodule

FILE: rtl/adp_history.sv
// Sample history kept in logical order, with the ring pointer.
module adp_history
  import adp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  hist_upd_t             upd,
  output logic [DATA_W-1:0]     hist_a,
  output logic [DATA_W-1:0]     hist_b,
  output logic [HIST_IDX_W-1:0] ptr
);

  logic [DATA_W-1:0]     hist      [HIST_DEPTH];
  logic [DATA_W-1:0]     hist_next [HIST_DEPTH];
  logic [DATA_W-1:0]     tmp       [HIST_DEPTH];
  logic [HIST_IDX_W-1:0] ptr_next;

  assign hist_a = hist[0];
  assign hist_b = hist[1];

  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_next[i] = hist[i];
      tmp[i]       = hist[i];
    end
    ptr_next = ptr;
    if (upd.fire) begin
      if (upd.load) begin
        // Unrotate to physical order, write the slot, pointer drops to zero.
        for (int j = 0; j < HIST_DEPTH; j++) begin
          tmp[j] = hist[HIST_IDX_W'(j) - ptr];
        end
        tmp[upd.slot] = upd.data;
        for (int j = 0; j < HIST_DEPTH; j++) begin
          hist_next[j] = tmp[j];
        end
        ptr_next = '0;
      end else if (upd.linear) begin
        hist_next[1] = hist[0];
        hist_next[0] = upd.data;
      end else begin
        tmp[upd.term_idx] = upd.data;
        for (int i = 0; i < HIST_DEPTH; i++) begin
          hist_next[i] = tmp[HIST_IDX_W'(i) + HIST_IDX_W'(1)];
        end
        ptr_next = ptr + HIST_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
      ptr <= '0;
    end else begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= hist_next[i];
      end
      ptr <= ptr_next;
    end
  end

endmodule
